/* rtl/core/iirs_pkg.sv */
// shared constants, types and codes for the integral image rectangle sum block
package iirs_pkg;

    localparam int MAX_ROWS   = 256;
    localparam int MAX_COLS   = 256;
    localparam int PIXEL_BITS = 8;

    localparam int ROW_W     = $clog2(MAX_ROWS);
    localparam int COL_W     = $clog2(MAX_COLS);
    localparam int ADDR_W    = ROW_W + COL_W;
    localparam int SUM_W     = 24;
    localparam int RUN_W     = 16;
    localparam int DIM_W     = 9;
    localparam int COORD_W   = 8;
    localparam int PIX_IN_W  = 8;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_ROWS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_COLS = CFG_IDX_W'(1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_QRY_RD2,
        S_QRY_SUM
    } t_state;

    typedef enum logic [1:0] {
        ST_QUERY_OK     = 2'd0,
        ST_PIXEL_STORED = 2'd1,
        ST_BAD_RECT     = 2'd2,
        ST_NO_FRAME     = 2'd3
    } t_status;

    // table access issued by the control logic
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [SUM_W-1:0]  wdata;
        logic [ADDR_W-1:0] raddr_a;
        logic [ADDR_W-1:0] raddr_b;
    } t_tbl_req;

endpackage

/* rtl/core/integral_image_rect_sum.sv */
// top level: summed-area table build and rectangle sum queries
//
//  channel   ports                                              handshake
//  --------  -------------------------------------------------  -----------------------
//  command   i_mode i_pixel i_top_row i_left_col                beat on i_start & !o_busy
//            i_rect_height i_rect_width
//  result    o_sum o_status                                     beat on o_valid, 1 cycle
//  config    i_cfg_index i_cfg_data                             write on i_cfg_we
//
// a pixel load reads the entry above, then does the table write;
// its result shows in the cycle after.
// a query: two table reads on the beat, two more in S_QRY_RD2, then the final sum;
// the next beat is taken during the final sum cycle, before the result shows.
// reset is synchronous, active low; table contents are left as they are.
// the receiver cannot stall: each result is shown for exactly one cycle.
module integral_image_rect_sum
    import iirs_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    output logic                 o_busy,
    input  logic                 i_mode,
    input  logic [PIX_IN_W-1:0]  i_pixel,
    input  logic [COORD_W-1:0]   i_top_row,
    input  logic [COORD_W-1:0]   i_left_col,
    input  logic [DIM_W-1:0]     i_rect_height,
    input  logic [DIM_W-1:0]     i_rect_width,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DIM_W-1:0]     i_cfg_data,
    output logic                 o_valid,
    output logic [SUM_W-1:0]     o_sum,
    output logic [1:0]           o_status
);

    t_state r_state, n_state;

    logic [DIM_W-1:0]      r_rows, r_cols;
    logic [ROW_W-1:0]      r_load_row;
    logic [COL_W-1:0]      r_load_col;
    logic [RUN_W-1:0]      r_run;
    logic                  r_frame_ready;

    logic [PIXEL_BITS-1:0] r_pix;
    logic [ROW_W-1:0]      r_dr, r_tm1;
    logic [COL_W-1:0]      r_lm1;
    logic                  r_top_nz, r_left_nz;
    t_status               r_q_status;
    logic [SUM_W-1:0]      r_partial;

    logic                  r_out_valid, n_out_valid;
    logic [SUM_W-1:0]      r_sum, n_sum;
    t_status               r_status, n_status;

    logic                  w_accept;
    logic [DIM_W:0]        w_row_end, w_col_end;
    logic                  w_rect_ok;
    logic [ROW_W-1:0]      w_dr, w_tm1, w_above_row;
    logic [COL_W-1:0]      w_dc, w_lm1;
    t_status               w_q_status;
    logic [RUN_W-1:0]      w_run_next;
    logic [SUM_W-1:0]      w_above, w_entry, w_qsum;
    logic                  w_col_last, w_row_last;

    t_tbl_req              w_req;
    logic [SUM_W-1:0]      w_rdata_a, w_rdata_b;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input int maxv);
        logic [DIM_W-1:0] res;
        res = v;
        if (v == '0) begin
            res = DIM_W'(1);
        end else if (int'(v) > maxv) begin
            res = DIM_W'(maxv);
        end
        return res;
    endfunction

    assign w_accept = i_start && !o_busy;
    assign o_busy   = !(r_state == S_IDLE || r_state == S_QRY_SUM);

    // query corners from the command fields
    assign w_row_end = {2'b00, i_top_row} + {1'b0, i_rect_height};
    assign w_col_end = {2'b00, i_left_col} + {1'b0, i_rect_width};
    assign w_rect_ok = (i_rect_height != '0) && (i_rect_width != '0)
                       && (w_row_end <= {1'b0, r_rows}) && (w_col_end <= {1'b0, r_cols});
    assign w_dr  = ROW_W'(w_row_end - (DIM_W+1)'(1));
    assign w_dc  = COL_W'(w_col_end - (DIM_W+1)'(1));
    assign w_tm1 = ROW_W'(i_top_row - COORD_W'(1));
    assign w_lm1 = COL_W'(i_left_col - COORD_W'(1));
    assign w_q_status = !r_frame_ready ? ST_NO_FRAME :
                        (!w_rect_ok ? ST_BAD_RECT : ST_QUERY_OK);

    // load path
    assign w_above_row = r_load_row - ROW_W'(1);
    assign w_run_next  = r_run + RUN_W'(r_pix);
    assign w_above     = (r_load_row != '0) ? w_rdata_a : '0;
    assign w_entry     = w_above + SUM_W'(w_run_next);
    assign w_col_last  = ({1'b0, r_load_col} + (COL_W+1)'(1)) >= (COL_W+1)'(r_cols);
    assign w_row_last  = ({1'b0, r_load_row} + (ROW_W+1)'(1)) >= (ROW_W+1)'(r_rows);

    // d - b was folded into r_partial; now subtract c and add back a
    assign w_qsum = r_partial - (r_left_nz ? w_rdata_a : '0)
                    + ((r_top_nz && r_left_nz) ? w_rdata_b : '0);

    always_comb begin
        w_req.we      = (r_state == S_LOAD);
        w_req.waddr   = {r_load_row, r_load_col};
        w_req.wdata   = w_entry;
        w_req.raddr_a = i_mode ? {w_dr, w_dc} : {w_above_row, r_load_col};
        w_req.raddr_b = {w_tm1, w_dc};
        if (r_state == S_QRY_RD2) begin
            w_req.raddr_a = {r_dr, r_lm1};
            w_req.raddr_b = {r_tm1, r_lm1};
        end
    end

    iirs_table u_table (
        .i_clk     (i_clk),
        .i_req     (w_req),
        .o_rdata_a (w_rdata_a),
        .o_rdata_b (w_rdata_b)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE, S_QRY_SUM: begin
                n_state = S_IDLE;
                if (w_accept) begin
                    n_state = i_mode ? S_QRY_RD2 : S_LOAD;
                end
            end
            S_LOAD:    n_state = S_IDLE;
            S_QRY_RD2: n_state = S_QRY_SUM;
            default:   n_state = S_IDLE;
        endcase
    end

    // result beat
    always_comb begin
        n_out_valid = 1'b0;
        n_sum       = r_sum;
        n_status    = r_status;
        case (r_state)
            S_LOAD: begin
                n_out_valid = 1'b1;
                n_sum       = w_entry;
                n_status    = ST_PIXEL_STORED;
            end
            S_QRY_SUM: begin
                n_out_valid = 1'b1;
                n_sum       = (r_q_status == ST_QUERY_OK) ? w_qsum : '0;
                n_status    = r_q_status;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum    <= n_sum;
        r_status <= n_status;
        if (w_accept) begin
            r_pix      <= i_pixel[PIXEL_BITS-1:0];
            r_dr       <= w_dr;
            r_tm1      <= w_tm1;
            r_lm1      <= w_lm1;
            r_top_nz   <= (i_top_row != '0);
            r_left_nz  <= (i_left_col != '0);
            r_q_status <= w_q_status;
        end
        if (r_state == S_QRY_RD2) begin
            r_partial <= w_rdata_a - (r_top_nz ? w_rdata_b : '0);
        end
    end

    // image size, load position, row running sum and frame status
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows        <= clamp_dim(DIM_W'(256), MAX_ROWS);
            r_cols        <= clamp_dim(DIM_W'(256), MAX_COLS);
            r_load_row    <= '0;
            r_load_col    <= '0;
            r_run         <= '0;
            r_frame_ready <= 1'b0;
        end else if (i_cfg_we && (i_cfg_index == REG_IMAGE_ROWS
                                  || i_cfg_index == REG_IMAGE_COLS)) begin
            if (i_cfg_index == REG_IMAGE_ROWS) begin
                r_rows <= clamp_dim(i_cfg_data, MAX_ROWS);
            end else begin
                r_cols <= clamp_dim(i_cfg_data, MAX_COLS);
            end
            r_load_row    <= '0;
            r_load_col    <= '0;
            r_run         <= '0;
            r_frame_ready <= 1'b0;
        end else if (r_state == S_LOAD) begin
            if (r_load_row == '0 && r_load_col == '0) begin
                r_frame_ready <= 1'b0;
            end
            if (w_col_last) begin
                r_load_col <= '0;
                r_run      <= '0;
                if (w_row_last) begin
                    r_load_row    <= '0;
                    r_frame_ready <= 1'b1;
                end else begin
                    r_load_row <= r_load_row + ROW_W'(1);
                end
            end else begin
                r_load_col <= r_load_col + COL_W'(1);
                r_run      <= w_run_next;
            end
        end
    end

    assign o_valid  = r_out_valid;
    assign o_sum    = r_sum;
    assign o_status = r_status;

`ifndef NO_ASSERTIONS
    a_load_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !i_mode) |=> ##1 (o_valid && o_status == ST_PIXEL_STORED))
        else $error("load beat did not produce a stored-pixel result");

    a_query_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_mode && r_frame_ready && w_rect_ok)
        |=> ##2 (o_valid && o_status == ST_QUERY_OK))
        else $error("valid query did not produce an ok result");

    a_no_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_mode && !r_frame_ready)
        |=> ##2 (o_valid && o_status == ST_NO_FRAME && o_sum == '0))
        else $error("query before frame load not flagged");

    a_load_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_load_row} < r_rows) && ({1'b0, r_load_col} < r_cols))
        else $error("load position outside the image");
`endif

endmodule

/* rtl/core/iirs_table.sv */
// summed-area table storage: one write port, two registered read ports
module iirs_table
    import iirs_pkg::*;
(
    input  logic             i_clk,
    input  t_tbl_req         i_req,
    output logic [SUM_W-1:0] o_rdata_a,
    output logic [SUM_W-1:0] o_rdata_b
);

    logic [SUM_W-1:0] r_mem [2**ADDR_W];
    logic [SUM_W-1:0] r_rdata_a;
    logic [SUM_W-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata_a <= r_mem[i_req.raddr_a];
        r_rdata_b <= r_mem[i_req.raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule
